// ----- hdl/scab_pkg.sv -----
// shared constants, types and register codes of the shape coverage alpha blend unit
`default_nettype none
package scab_pkg;

  // supersample factor, a power of two
  localparam int SUPERSAMPLE       = 4;
  localparam int SAMPLE_COORD_BITS = 12;

  localparam int SAMPLE_W = 12;
  localparam int COLOR_W  = 8;
  localparam int ALPHA_W  = 9;
  localparam int MAT_W    = 20;
  localparam int GEO_W    = 24;
  localparam int KIND_W   = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int USED_BITS = (SAMPLE_COORD_BITS < SAMPLE_W) ? SAMPLE_COORD_BITS : SAMPLE_W;
  localparam int SS_SHIFT  = $clog2(SUPERSAMPLE) + COLOR_W;
  localparam int CRD_W     = USED_BITS + 1;
  localparam int PM_W      = MAT_W + CRD_W;
  localparam int S_W       = ((PM_W + 1 > GEO_W + SS_SHIFT) ? PM_W + 1 : GEO_W + SS_SHIFT) + 1;
  localparam int OBJ_W     = S_W - SS_SHIFT;
  localparam int DIFF_W    = ((OBJ_W > GEO_W) ? OBJ_W : GEO_W) + 1;
  localparam int VEC_W     = GEO_W + 1;
  localparam int EP_W      = DIFF_W + VEC_W;
  localparam int EDGE_W    = EP_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int R2_W      = 2 * GEO_W;
  localparam int BL_W      = 2 * COLOR_W + 1;

  localparam logic [ALPHA_W-1:0] OPAQUE = ALPHA_W'(1 << COLOR_W);
  localparam logic [BL_W-1:0]    ROUND  = BL_W'(1 << (COLOR_W - 1));

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHAPE_KIND = 3'd0,
    REG_INV_ROW_X  = 3'd1,
    REG_INV_ROW_Y  = 3'd2,
    REG_GEOM_A     = 3'd3,
    REG_GEOM_B     = 3'd4,
    REG_GEOM_C     = 3'd5,
    REG_PAINT      = 3'd6
  } reg_index_e;

  typedef enum logic [KIND_W-1:0] {
    SHAPE_CIRCLE = 2'd0,
    SHAPE_RECT   = 2'd1,
    SHAPE_TRI    = 2'd2
  } shape_e;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [COLOR_W-1:0]  dest_red;
    logic [COLOR_W-1:0]  dest_green;
    logic [COLOR_W-1:0]  dest_blue;
  } sample_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               covered;
  } pixel_t;

  typedef struct packed {
    shape_e                    shape_kind;
    logic signed [MAT_W-1:0]   m00;
    logic signed [MAT_W-1:0]   m01;
    logic signed [GEO_W-1:0]   m02;
    logic signed [MAT_W-1:0]   m10;
    logic signed [MAT_W-1:0]   m11;
    logic signed [GEO_W-1:0]   m12;
    logic signed [GEO_W-1:0]   ax;
    logic signed [GEO_W-1:0]   ay;
    logic signed [GEO_W-1:0]   bx;
    logic signed [GEO_W-1:0]   by;
    logic signed [GEO_W-1:0]   cx;
    logic signed [GEO_W-1:0]   cy;
    color_t                    paint;
    logic [ALPHA_W-1:0]        alpha;
  } cfg_t;

  typedef struct packed {
    logic signed [OBJ_W-1:0] ox;
    logic signed [OBJ_W-1:0] oy;
    color_t                  dest;
  } obj_t;

  typedef struct packed {
    logic   covered;
    color_t dest;
  } cover_t;

endpackage
`default_nettype wire

// ----- hdl/scab_xform.sv -----
// inverse affine transform of the sample position, two register stages
`default_nettype none
module scab_xform (
  input  logic             clk,
  input  logic             rst,
  input  scab_pkg::cfg_t    cfg,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  scab_pkg::sample_t sample,
  output logic             obj_valid,
  input  logic             obj_ready,
  output scab_pkg::obj_t    obj
);
  import scab_pkg::*;

  logic v1, v2, ready1, ready2;
  logic signed [CRD_W-1:0] sx, sy;
  logic signed [PM_W-1:0]  pxa_next, pxb_next, pya_next, pyb_next;
  logic signed [PM_W-1:0]  pxa, pxb, pya, pyb;
  color_t                  dest1;
  logic signed [S_W-1:0]   sum_x, sum_y;

  assign ready2       = !v2 || obj_ready;
  assign ready1       = !v1 || ready2;
  assign sample_ready = ready1;
  assign obj_valid    = v2;

  assign sx = $signed({1'b0, sample.sample_x[USED_BITS-1:0]});
  assign sy = $signed({1'b0, sample.sample_y[USED_BITS-1:0]});

  always_comb begin
    pxa_next = $signed(cfg.m00) * sx;
    pxb_next = $signed(cfg.m01) * sy;
    pya_next = $signed(cfg.m10) * sx;
    pyb_next = $signed(cfg.m11) * sy;
  end

  always_comb begin
    sum_x = S_W'(pxa) + S_W'(pxb) + (S_W'($signed(cfg.m02)) <<< SS_SHIFT);
    sum_y = S_W'(pya) + S_W'(pyb) + (S_W'($signed(cfg.m12)) <<< SS_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= sample_valid;
      if (ready2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && sample_valid) begin
      pxa   <= pxa_next;
      pxb   <= pxb_next;
      pya   <= pya_next;
      pyb   <= pyb_next;
      dest1 <= '{red: sample.dest_red, green: sample.dest_green, blue: sample.dest_blue};
    end
    if (ready2 && v1) begin
      // floor division by the sample scale is an arithmetic shift
      obj.ox   <= sum_x[S_W-1:SS_SHIFT];
      obj.oy   <= sum_y[S_W-1:SS_SHIFT];
      obj.dest <= dest1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scab_cover.sv -----
// coverage test against circle, rectangle or triangle, three register stages
`default_nettype none
module scab_cover (
  input  logic            clk,
  input  logic            rst,
  input  scab_pkg::cfg_t   cfg,
  input  logic            obj_valid,
  output logic            obj_ready,
  input  scab_pkg::obj_t   obj,
  output logic            cov_valid,
  input  logic            cov_ready,
  output scab_pkg::cover_t cov
);
  import scab_pkg::*;

  logic v3, v4, v5, ready3, ready4, ready5;

  // stage 3: offsets from the vertices
  logic signed [DIFF_W-1:0] d0x, d0y, d1x, d1y, d2x, d2y;
  logic                     rect3, rect4;
  color_t                   dest3, dest4;

  // stage 4: products
  logic signed [VEC_W-1:0]  v0x, v0y, v1x, v1y, v2x, v2y;
  logic signed [EP_W-1:0]   e0p_next, e0q_next, e1p_next, e1q_next, e2p_next, e2q_next;
  logic signed [EP_W-1:0]   e0p, e0q, e1p, e1q, e2p, e2q;
  logic signed [SQ_W-1:0]   sqx_next, sqy_next, sqx, sqy;
  logic signed [R2_W-1:0]   r2_next, r2;

  // stage 5: signs and compares
  logic signed [EDGE_W-1:0] e0, e1, e2;
  logic signed [D2_W-1:0]   d2;
  logic                     circ_in, tri_in, covered_next;

  assign ready5    = !v5 || cov_ready;
  assign ready4    = !v4 || ready5;
  assign ready3    = !v3 || ready4;
  assign obj_ready = ready3;
  assign cov_valid = v5;

  always_comb begin
    v0x = VEC_W'($signed(cfg.bx)) - VEC_W'($signed(cfg.ax));
    v0y = VEC_W'($signed(cfg.by)) - VEC_W'($signed(cfg.ay));
    v1x = VEC_W'($signed(cfg.cx)) - VEC_W'($signed(cfg.bx));
    v1y = VEC_W'($signed(cfg.cy)) - VEC_W'($signed(cfg.by));
    v2x = VEC_W'($signed(cfg.ax)) - VEC_W'($signed(cfg.cx));
    v2y = VEC_W'($signed(cfg.ay)) - VEC_W'($signed(cfg.cy));
    e0p_next = d0x * v0y;
    e0q_next = d0y * v0x;
    e1p_next = d1x * v1y;
    e1q_next = d1y * v1x;
    e2p_next = d2x * v2y;
    e2q_next = d2y * v2x;
    sqx_next = d0x * d0x;
    sqy_next = d0y * d0y;
    r2_next  = $signed(cfg.bx) * $signed(cfg.bx);
  end

  always_comb begin
    e0      = e0p - e0q;
    e1      = e1p - e1q;
    e2      = e2p - e2q;
    d2      = sqx + sqy;
    circ_in = ($signed(cfg.bx) > 0) && (d2 < r2);
    tri_in  = (e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0);
    unique case (cfg.shape_kind)
      SHAPE_CIRCLE: covered_next = circ_in;
      SHAPE_RECT:   covered_next = rect4;
      SHAPE_TRI:    covered_next = tri_in;
      default:      covered_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready3) v3 <= obj_valid;
      if (ready4) v4 <= v3;
      if (ready5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && obj_valid) begin
      d0x   <= DIFF_W'($signed(obj.ox)) - DIFF_W'($signed(cfg.ax));
      d0y   <= DIFF_W'($signed(obj.oy)) - DIFF_W'($signed(cfg.ay));
      d1x   <= DIFF_W'($signed(obj.ox)) - DIFF_W'($signed(cfg.bx));
      d1y   <= DIFF_W'($signed(obj.oy)) - DIFF_W'($signed(cfg.by));
      d2x   <= DIFF_W'($signed(obj.ox)) - DIFF_W'($signed(cfg.cx));
      d2y   <= DIFF_W'($signed(obj.oy)) - DIFF_W'($signed(cfg.cy));
      rect3 <= ($signed(obj.ox) > $signed(cfg.ax)) && ($signed(obj.ox) < $signed(cfg.bx)) &&
               ($signed(obj.oy) > $signed(cfg.ay)) && ($signed(obj.oy) < $signed(cfg.by));
      dest3 <= obj.dest;
    end
    if (ready4 && v3) begin
      e0p   <= e0p_next;
      e0q   <= e0q_next;
      e1p   <= e1p_next;
      e1q   <= e1q_next;
      e2p   <= e2p_next;
      e2q   <= e2q_next;
      sqx   <= sqx_next;
      sqy   <= sqy_next;
      r2    <= r2_next;
      rect4 <= rect3;
      dest4 <= dest3;
    end
    if (ready5 && v4) begin
      cov.covered <= covered_next;
      cov.dest    <= dest4;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scab_blend.sv -----
// alpha blend of covered samples into the output register, uncovered samples keep their stored color
`default_nettype none
module scab_blend (
  input  logic            clk,
  input  logic            rst,
  input  scab_pkg::cfg_t   cfg,
  input  logic            cov_valid,
  output logic            cov_ready,
  input  scab_pkg::cover_t cov,
  output logic            pixel_valid,
  input  logic            pixel_ready,
  output scab_pkg::pixel_t pixel
);
  import scab_pkg::*;

  logic               pv, ready6;
  logic [ALPHA_W-1:0] alpha_sat;
  pixel_t             pixel_next;

  function automatic logic [COLOR_W-1:0] blend_ch(input logic [COLOR_W-1:0] p,
                                                  input logic [COLOR_W-1:0] d,
                                                  input logic [ALPHA_W-1:0] a);
    logic [BL_W-1:0] acc;
    acc = BL_W'(p) * BL_W'(a) + BL_W'(d) * BL_W'(OPAQUE - a) + ROUND;
    return acc[2*COLOR_W-1:COLOR_W];
  endfunction

  assign ready6      = !pv || pixel_ready;
  assign cov_ready   = ready6;
  assign pixel_valid = pv;

  // alpha above opaque saturates
  assign alpha_sat = (cfg.alpha > OPAQUE) ? OPAQUE : cfg.alpha;

  always_comb begin
    if (cov.covered) begin
      pixel_next.out_red   = blend_ch(cfg.paint.red,   cov.dest.red,   alpha_sat);
      pixel_next.out_green = blend_ch(cfg.paint.green, cov.dest.green, alpha_sat);
      pixel_next.out_blue  = blend_ch(cfg.paint.blue,  cov.dest.blue,  alpha_sat);
    end else begin
      pixel_next.out_red   = cov.dest.red;
      pixel_next.out_green = cov.dest.green;
      pixel_next.out_blue  = cov.dest.blue;
    end
    pixel_next.covered = cov.covered;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (ready6) begin
      pv <= cov_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready6 && cov_valid) begin
      pixel <= pixel_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/shape_coverage_alpha_blend_unit.sv -----
// top level: configuration registers, transform, coverage and blend pipeline
//
//   channel   signals                          word
//   sample    sample_valid sample_ready        sample_t: position and stored color
//   pixel     pixel_valid  pixel_ready         pixel_t: output color and covered flag
//   config    cfg_write cfg_index cfg_data     one register write per cycle, no wait
//
// one word per cycle sustained while the output is ready; the pipeline registers are two transform stages,
// three coverage stages (offsets, products, compares) and the blend register
// every stage has its own valid bit and takes a word when it is empty or its
// successor moves, so a stalled output holds while bubbles upstream fill in
// synchronous reset clears the valid bits and all configuration registers
`default_nettype none
module shape_coverage_alpha_blend_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  scab_pkg::sample_t                 sample,
  output logic                             pixel_valid,
  input  logic                             pixel_ready,
  output scab_pkg::pixel_t                  pixel,
  input  logic                             cfg_write,
  input  logic [scab_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scab_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scab_pkg::*;

  cfg_t   cfg;
  logic   xf_valid, xf_ready, cv_valid, cv_ready;
  obj_t   xf_obj;
  cover_t cv_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHAPE_KIND: cfg.shape_kind <= shape_e'(cfg_data[KIND_W-1:0]);
        REG_INV_ROW_X: begin
          cfg.m00 <= cfg_data[MAT_W-1:0];
          cfg.m01 <= cfg_data[2*MAT_W-1:MAT_W];
          cfg.m02 <= cfg_data[2*MAT_W+GEO_W-1:2*MAT_W];
        end
        REG_INV_ROW_Y: begin
          cfg.m10 <= cfg_data[MAT_W-1:0];
          cfg.m11 <= cfg_data[2*MAT_W-1:MAT_W];
          cfg.m12 <= cfg_data[2*MAT_W+GEO_W-1:2*MAT_W];
        end
        REG_GEOM_A: begin
          cfg.ax <= cfg_data[GEO_W-1:0];
          cfg.ay <= cfg_data[2*GEO_W-1:GEO_W];
        end
        REG_GEOM_B: begin
          cfg.bx <= cfg_data[GEO_W-1:0];
          cfg.by <= cfg_data[2*GEO_W-1:GEO_W];
        end
        REG_GEOM_C: begin
          cfg.cx <= cfg_data[GEO_W-1:0];
          cfg.cy <= cfg_data[2*GEO_W-1:GEO_W];
        end
        REG_PAINT: begin
          cfg.paint.red   <= cfg_data[COLOR_W-1:0];
          cfg.paint.green <= cfg_data[2*COLOR_W-1:COLOR_W];
          cfg.paint.blue  <= cfg_data[3*COLOR_W-1:2*COLOR_W];
          cfg.alpha       <= cfg_data[3*COLOR_W+ALPHA_W-1:3*COLOR_W];
        end
        default: ;
      endcase
    end
  end

  scab_xform u_xform (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .obj_valid    (xf_valid),
    .obj_ready    (xf_ready),
    .obj          (xf_obj)
  );

  scab_cover u_cover (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .obj_valid (xf_valid),
    .obj_ready (xf_ready),
    .obj       (xf_obj),
    .cov_valid (cv_valid),
    .cov_ready (cv_ready),
    .cov       (cv_word)
  );

  scab_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cov_valid   (cv_valid),
    .cov_ready   (cv_ready),
    .cov         (cv_word),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  a_free_output_ready: assert property (@(posedge clk) disable iff (rst)
    (!pixel_valid || pixel_ready) |-> sample_ready)
    else $error("input not ready although output stage can move");

  a_obj_hold: assert property (@(posedge clk) disable iff (rst)
    (xf_valid && !xf_ready) |=> xf_valid)
    else $error("transform word lost while stalled");

  a_cov_hold: assert property (@(posedge clk) disable iff (rst)
    (cv_valid && !cv_ready) |=> cv_valid)
    else $error("coverage word lost while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// ----- test/tb_shape_coverage_alpha_blend_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the shape coverage alpha blend unit
module tb_shape_coverage_alpha_blend_unit;
  import scab_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED  = 3'd7;
  localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1700;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SPAN         = 1024 * 256;

  typedef struct {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    sample_t                word;
    logic                   known;
    pixel_t                 want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_ready;
  sample_t                sample_word = '0;
  logic                   pixel_valid;
  logic                   pixel_ready = 1'b0;
  pixel_t                 pixel;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // shadow copy of the register file
  logic [KIND_W-1:0] kind_reg = '0;
  logic [63:0]       row_x = '0;
  logic [63:0]       row_y = '0;
  logic [47:0]       geo_a = '0;
  logic [47:0]       geo_b = '0;
  logic [47:0]       geo_c = '0;
  logic [32:0]       paint_reg = '0;

  pixel_t    pixels_due[$];
  pixel_t    head_pixel;
  plan_row_t plan[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  logic [7:0] recv_tick = '0;
  bit        recv_calm = 1'b0;
  bit        send_calm = 1'b0;
  int        sent;
  int        burst;

  int m20_ext[4]   = '{32'h80000, 32'h7FFFF, 0, 32'h10000};
  int m24_ext[3]   = '{32'h800000, 32'h7FFFFF, 0};
  int alpha_ext[7] = '{0, 1, 128, 255, 256, 257, 511};

  shape_coverage_alpha_blend_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_word),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sample_t word_of(int x, int y, int r, int g, int b);
    return {x[11:0], y[11:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic pixel_t px_of(int r, int g, int b, logic c);
    return {r[7:0], g[7:0], b[7:0], c};
  endfunction

  function automatic logic [63:0] row_word(int ma, int mb, int mc);
    return {mc[23:0], mb[19:0], ma[19:0]};
  endfunction

  function automatic logic [63:0] xy_word(int x, int y);
    return {16'($urandom), y[23:0], x[23:0]};
  endfunction

  function automatic logic [63:0] paint_word(int r, int g, int b, int a);
    return {31'($urandom), a[8:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic int srand(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    plan.push_back('{1'b1, idx, data, '0, 1'b0, '0});
  endfunction

  function automatic void add_smp(sample_t w);
    plan.push_back('{1'b0, '0, '0, w, 1'b0, '0});
  endfunction

  function automatic void add_known(sample_t w, pixel_t p);
    plan.push_back('{1'b0, '0, '0, w, 1'b1, p});
  endfunction

  // object coordinate in Q.8, floor of the exact transform
  function automatic longint map_obj(logic [63:0] row, longint sx, longint sy);
    longint acc;
    acc = longint'($signed(row[19:0])) * sx + longint'($signed(row[39:20])) * sy
        + longint'($signed(row[63:40])) * (SUPERSAMPLE * 256);
    return acc >>> SS_SHIFT;
  endfunction

  function automatic longint side_of(longint qx, longint qy, longint px, longint py,
                                     longint rx, longint ry);
    return (qx - px) * (ry - py) - (qy - py) * (rx - px);
  endfunction

  function automatic logic [7:0] mix(logic [7:0] p, logic [7:0] d, int unsigned a);
    int unsigned sum;
    sum = p * a + d * (256 - a) + 128;
    return sum[15:8];
  endfunction

  function automatic pixel_t blend_pixel(sample_t s);
    longint sx, sy, ox, oy, ax, ay, bx, by, cx, cy, dx, dy, e0, e1, e2;
    logic hit;
    int unsigned a;
    sx = s.sample_x;
    sy = s.sample_y;
    ox = map_obj(row_x, sx, sy);
    oy = map_obj(row_y, sx, sy);
    ax = longint'($signed(geo_a[23:0]));
    ay = longint'($signed(geo_a[47:24]));
    bx = longint'($signed(geo_b[23:0]));
    by = longint'($signed(geo_b[47:24]));
    cx = longint'($signed(geo_c[23:0]));
    cy = longint'($signed(geo_c[47:24]));
    hit = 1'b0;
    case (kind_reg)
      SHAPE_CIRCLE: begin
        dx = ox - ax;
        dy = oy - ay;
        hit = bx > 0 && dx * dx + dy * dy < bx * bx;
      end
      SHAPE_RECT: hit = ox > ax && ox < bx && oy > ay && oy < by;
      SHAPE_TRI: begin
        e0 = side_of(ox, oy, ax, ay, bx, by);
        e1 = side_of(ox, oy, bx, by, cx, cy);
        e2 = side_of(ox, oy, cx, cy, ax, ay);
        hit = (e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0);
      end
      default: hit = 1'b0;
    endcase
    if (!hit) return {s.dest_red, s.dest_green, s.dest_blue, 1'b0};
    a = paint_reg[32:24];
    if (a > 256) a = 256;
    return {mix(paint_reg[7:0], s.dest_red, a), mix(paint_reg[15:8], s.dest_green, a),
            mix(paint_reg[23:16], s.dest_blue, a), 1'b1};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic settle();
    sample_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SHAPE_KIND: kind_reg = data[1:0];
      REG_INV_ROW_X:  row_x = data;
      REG_INV_ROW_Y:  row_y = data;
      REG_GEOM_A:     geo_a = data[47:0];
      REG_GEOM_B:     geo_b = data[47:0];
      REG_GEOM_C:     geo_c = data[47:0];
      REG_PAINT:      paint_reg = data[32:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(sample_t s, logic known, pixel_t want);
    int gap;
    gap = pick_gap();
    cfg_write <= 1'b0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_word  <= s;
    do @(posedge clk); while (!sample_ready);
    pixels_due.push_back(known ? want : blend_pixel(s));
  endtask

  task automatic random_setup();
    int roll, style, ax, ay, bx, by, cx, cy, r;
    logic [KIND_W-1:0] kind;
    logic [63:0] rx, ry;
    settle();
    roll = $urandom_range(0, 9);
    kind = roll < 3 ? SHAPE_CIRCLE : roll < 6 ? SHAPE_RECT : roll < 9 ? SHAPE_TRI : KIND_UNUSED;
    style = $urandom_range(0, 7);
    if (style == 0) begin
      rx = {$urandom, $urandom};
      ry = {$urandom, $urandom};
    end else if (style == 1) begin
      rx = row_word(m20_ext[$urandom_range(0, 3)], m20_ext[$urandom_range(0, 3)],
                    m24_ext[$urandom_range(0, 2)]);
      ry = row_word(m20_ext[$urandom_range(0, 3)], m20_ext[$urandom_range(0, 3)],
                    m24_ext[$urandom_range(0, 2)]);
    end else begin
      rx = row_word(65536 + srand(32768), srand(16384), srand(16384));
      ry = row_word(srand(16384), 65536 + srand(32768), srand(16384));
    end
    ax = $urandom_range(0, SPAN);
    ay = $urandom_range(0, SPAN);
    bx = $urandom_range(0, SPAN);
    by = $urandom_range(0, SPAN);
    cx = $urandom_range(0, SPAN);
    cy = $urandom_range(0, SPAN);
    r = $urandom_range(0, 9);
    case (kind)
      SHAPE_CIRCLE: begin
        bx = r == 0 ? 0 : r == 1 ? -int'($urandom_range(1, SPAN)) :
             r == 2 ? 32'h7FFFFF : int'($urandom_range(256, 300 * 256));
        by = $urandom;
      end
      SHAPE_RECT: begin
        bx = ax + int'($urandom_range(0, 600 * 256)) - (r == 0 ? 700 * 256 : 0);
        by = ay + int'($urandom_range(0, 600 * 256)) - (r == 1 ? 700 * 256 : 0);
      end
      SHAPE_TRI: begin
        if (r == 0) begin
          bx = ax;
          by = ay;
          cx = ax;
          cy = ay;
        end else if (r == 1) begin
          cx = 2 * bx - ax;
          cy = 2 * by - ay;
        end
      end
      default: ;
    endcase
    write_reg(REG_SHAPE_KIND, {32'($urandom), 30'($urandom), kind});
    write_reg(REG_INV_ROW_X, rx);
    write_reg(REG_INV_ROW_Y, ry);
    if ($urandom_range(0, 5) == 0) begin
      write_reg(REG_GEOM_A, {$urandom, $urandom});
      write_reg(REG_GEOM_B, {$urandom, $urandom});
      write_reg(REG_GEOM_C, {$urandom, $urandom});
    end else begin
      write_reg(REG_GEOM_A, xy_word(ax, ay));
      write_reg(REG_GEOM_B, xy_word(bx, by));
      write_reg(REG_GEOM_C, xy_word(cx, cy));
    end
    write_reg(REG_PAINT, paint_word($urandom, $urandom, $urandom,
              $urandom_range(0, 1) ? alpha_ext[$urandom_range(0, 6)] : $urandom_range(0, 511)));
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // output side: random back-pressure with calm stretches
  always @(posedge clk) begin
    recv_tick <= recv_tick + 8'd1;
    if (recv_tick == 8'd0) recv_calm <= ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      pixel_ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!recv_calm && $urandom_range(0, 99) < 20) begin
      pixel_ready <= 1'b0;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end else begin
      pixel_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected word, got %h", $time, pixel);
        errors++;
      end else begin
        head_pixel = pixels_due.pop_front();
        check_field("out_red", head_pixel.out_red, pixel.out_red);
        check_field("out_green", head_pixel.out_green, pixel.out_green);
        check_field("out_blue", head_pixel.out_blue, pixel.out_blue);
        check_field("covered", head_pixel.covered, pixel.covered);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (pixel_valid && pixel_ready) || cfg_write)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    // all registers zero: circle of radius zero, nothing covered
    add_known(word_of(0, 0, 0, 0, 0), px_of(0, 0, 0, 1'b0));
    add_known(word_of(4095, 4095, 255, 255, 255), px_of(255, 255, 255, 1'b0));
    add_known(word_of(12'hAAA, 12'h555, 8'hAA, 8'h55, 8'h0F), px_of(8'hAA, 8'h55, 8'h0F, 1'b0));
    add_cfg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_known(word_of(12'h555, 12'hAAA, 8'h55, 8'hAA, 8'hF0), px_of(8'h55, 8'hAA, 8'hF0, 1'b0));
    // zero transform inside a small rectangle: everything covered
    add_cfg(REG_SHAPE_KIND, SHAPE_RECT);
    add_cfg(REG_GEOM_A, xy_word(-1, -1));
    add_cfg(REG_GEOM_B, xy_word(1, 1));
    add_cfg(REG_PAINT, paint_word(8'h12, 8'h34, 8'h56, 256));
    add_known(word_of(123, 456, 0, 0, 0), px_of(8'h12, 8'h34, 8'h56, 1'b1));
    add_cfg(REG_PAINT, paint_word(8'h12, 8'h34, 8'h56, 511));
    add_known(word_of(4095, 0, 255, 255, 255), px_of(8'h12, 8'h34, 8'h56, 1'b1));
    add_cfg(REG_PAINT, paint_word(8'h12, 8'h34, 8'h56, 0));
    add_known(word_of(0, 4095, 8'h9A, 8'hBC, 8'hDE), px_of(8'h9A, 8'hBC, 8'hDE, 1'b1));
    add_cfg(REG_PAINT, paint_word(8'h12, 8'h34, 8'h56, 128));
    add_smp(word_of(7, 9, 255, 0, 128));
    add_cfg(REG_SHAPE_KIND, KIND_UNUSED);
    add_known(word_of(1, 2, 8'h11, 8'h22, 8'h33), px_of(8'h11, 8'h22, 8'h33, 1'b0));
    // identity transform, circle at 100,100 radius 50
    add_cfg(REG_INV_ROW_X, row_word(32'h10000, 0, 0));
    add_cfg(REG_INV_ROW_Y, row_word(0, 32'h10000, 0));
    add_cfg(REG_SHAPE_KIND, SHAPE_CIRCLE);
    add_cfg(REG_GEOM_A, xy_word(25600, 25600));
    add_cfg(REG_GEOM_B, xy_word(12800, 0));
    add_cfg(REG_PAINT, paint_word(8'hC0, 8'h40, 8'h80, 200));
    add_smp(word_of(400, 400, 10, 20, 30));
    add_smp(word_of(600, 400, 10, 20, 30));
    add_smp(word_of(599, 400, 10, 20, 30));
    add_cfg(REG_GEOM_B, xy_word(-12800, 0));
    add_smp(word_of(400, 400, 10, 20, 30));
    // rectangle 100..200, strict bounds
    add_cfg(REG_SHAPE_KIND, SHAPE_RECT);
    add_cfg(REG_GEOM_B, xy_word(51200, 51200));
    add_smp(word_of(400, 400, 1, 2, 3));
    add_smp(word_of(401, 401, 1, 2, 3));
    add_smp(word_of(800, 799, 1, 2, 3));
    // triangle in both windings, then degenerate
    add_cfg(REG_SHAPE_KIND, SHAPE_TRI);
    add_cfg(REG_GEOM_A, xy_word(0, 0));
    add_cfg(REG_GEOM_B, xy_word(102400, 0));
    add_cfg(REG_GEOM_C, xy_word(0, 102400));
    add_smp(word_of(100, 100, 50, 60, 70));
    add_smp(word_of(2000, 2000, 50, 60, 70));
    add_smp(word_of(0, 100, 50, 60, 70));
    add_cfg(REG_GEOM_B, xy_word(0, 102400));
    add_cfg(REG_GEOM_C, xy_word(102400, 0));
    add_smp(word_of(100, 100, 50, 60, 70));
    add_cfg(REG_GEOM_A, xy_word(25600, 25600));
    add_cfg(REG_GEOM_B, xy_word(25600, 25600));
    add_cfg(REG_GEOM_C, xy_word(25600, 25600));
    add_smp(word_of(400, 400, 50, 60, 70));
    // extreme matrix entries, huge circle at origin
    add_cfg(REG_INV_ROW_X, row_word(32'h80000, 32'h7FFFF, 32'h800000));
    add_cfg(REG_INV_ROW_Y, row_word(32'h7FFFF, 32'h80000, 32'h7FFFFF));
    add_cfg(REG_SHAPE_KIND, SHAPE_CIRCLE);
    add_cfg(REG_GEOM_A, xy_word(0, 0));
    add_cfg(REG_GEOM_B, xy_word(32'h7FFFFF, 0));
    add_smp(word_of(4095, 4095, 200, 100, 0));
    add_smp(word_of(0, 0, 200, 100, 0));
    add_smp(word_of(4095, 0, 200, 100, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i - 1].is_cfg) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].word, plan[i].known, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      random_setup();
      send_calm = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(20, 150);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        send_word(word_of($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom, $urandom, $urandom), 1'b0, '0);
        sent++;
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/scab_pkg.sv
hdl/scab_xform.sv
hdl/scab_cover.sv
hdl/scab_blend.sv
hdl/shape_coverage_alpha_blend_unit.sv
test/tb_shape_coverage_alpha_blend_unit.sv
